// File: design/ssmj_pkg.sv
// ----------------------------------------------------------------------------
// ssmj_pkg
// Shared types and constants of the sorted stream merge join.
// ----------------------------------------------------------------------------
package ssmj_pkg;

  localparam int SPOOL_DEPTH   = 32;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int SPOOL_AW      = $clog2(SPOOL_DEPTH);
  localparam int FILL_W        = $clog2(SPOOL_DEPTH + 1);
  localparam int NSLOT         = 3;
  localparam int SPOOL_W       = 32 + PAYLOAD_WIDTH;
  localparam logic [31:0] PAYLOAD_MASK = 32'((64'd1 << PAYLOAD_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    K_ROW, K_WANT_L, K_WANT_R, K_FIN, K_OVF
  } ssmj_kind_e;

  typedef enum logic [3:0] {
    PH_FIN, PH_FIRST_L, PH_FIRST_R, PH_SCAN_L, PH_SCAN_R, PH_MATCH_L,
    PH_MATCH_R, PH_EMPTY_LEFT, PH_EMPTY_RIGHT, PH_EQ_LEFT, PH_EQ_RIGHT,
    PH_SPOOL, PH_SPOOL_L, PH_DRAIN_L, PH_DRAIN_R
  } ssmj_phase_e;

  typedef enum logic [1:0] {
    G_IDLE, G_FIX, G_REPLAY
  } ssmj_gen_e;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] count;
    logic [31:0] payload;
    logic        ended;
  } ssmj_beat_t;

  typedef struct packed {
    ssmj_kind_e  kind;
    logic [31:0] key;
    logic [31:0] lc;
    logic [31:0] lp;
    logic [31:0] rc;
    logic [31:0] rp;
  } ssmj_slot_t;

  typedef struct packed {
    ssmj_slot_t slot;
    logic       last;
  } ssmj_gen_t;

  function automatic ssmj_slot_t ssmj_row(logic [31:0] key, logic [31:0] lc,
                                          logic [31:0] lp, logic [31:0] rc,
                                          logic [31:0] rp);
    ssmj_slot_t s;
    s.kind = K_ROW;
    s.key  = key;
    s.lc   = lc;
    s.lp   = lp;
    s.rc   = rc;
    s.rp   = rp;
    return s;
  endfunction

  function automatic ssmj_slot_t ssmj_ctl(ssmj_kind_e kind);
    ssmj_slot_t s;
    s      = '0;
    s.kind = kind;
    return s;
  endfunction

endpackage

// File: design/ssmj_in_if.sv
// ----------------------------------------------------------------------------
// ssmj_in_if
// Request channel: valid/ready with the delivered tuple.
// ----------------------------------------------------------------------------
interface ssmj_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] key;
  logic [31:0] count;
  logic [31:0] payload;

  modport source (output valid, req_type, key, count, payload, input ready);
  modport sink   (input valid, req_type, key, count, payload, output ready);
endinterface

// File: design/ssmj_out_if.sv
// ----------------------------------------------------------------------------
// ssmj_out_if
// Result channel: valid/ready with one result beat.
// ----------------------------------------------------------------------------
interface ssmj_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] match_key;
  logic [31:0] left_payload;
  logic [31:0] right_payload;
  logic [31:0] multiplicity;
  logic        last;

  modport source (output valid, kind, match_key, left_payload, right_payload,
                  multiplicity, last, input ready);
  modport sink   (input valid, kind, match_key, left_payload, right_payload,
                  multiplicity, last, output ready);
endinterface

// File: design/ssmj_ram.sv
// ----------------------------------------------------------------------------
// ssmj_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module ssmj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: design/ssmj_front.sv
// ----------------------------------------------------------------------------
// ssmj_front
// Accepts request beats, classifies end of stream, two entry queue.
// ----------------------------------------------------------------------------
module ssmj_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  ssmj_in_if.sink             in_i,
  output logic                q_valid_o,
  output ssmj_pkg::ssmj_beat_t q_data_o,
  input  logic                q_pop_i
);
  import ssmj_pkg::*;

  ssmj_beat_t ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  ssmj_beat_t nb;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;

  always_comb begin
    nb.req_type = in_i.req_type;
    nb.key      = in_i.key;
    nb.count    = in_i.count;
    nb.payload  = in_i.payload & PAYLOAD_MASK;
    nb.ended    = (in_i.count == 32'd0);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= nb;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (q_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = ent_q[rp_q];
endmodule

// File: design/ssmj_back.sv
// ----------------------------------------------------------------------------
// ssmj_back
// Join engine: executes one queued beat, holds tuple and spool state,
// sequences the resulting beats and spool replays.
// ----------------------------------------------------------------------------
module ssmj_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 drain_we_i,
  input  logic                 drain_i,
  input  logic                 q_valid_i,
  input  ssmj_pkg::ssmj_beat_t q_data_i,
  output logic                 q_pop_o,
  output logic                 gen_valid_o,
  output ssmj_pkg::ssmj_gen_t  gen_data_o,
  input  logic                 gen_ready_i
);
  import ssmj_pkg::*;

  logic        drain_q;
  ssmj_phase_e phase_q;
  logic [31:0] lk_q, lc_q, ld_q, lsk_q, lsc_q, lsd_q;
  logic [31:0] rk_q, rc_q, rd_q, rsk_q, rsc_q, rsd_q;
  logic [FILL_W-1:0] fill_q;
  logic        rse_q;

  ssmj_gen_e   gen_q, gen_d;
  ssmj_slot_t  slots_q [NSLOT];
  logic [1:0]  nfix_q, ptr_q, ptr_d;
  logic [FILL_W-1:0] idx_q, idx_d;
  logic        pend_q, pend_d;
  logic        wr2_q;
  logic [SPOOL_W-1:0] wdata2_q;

  // exec results
  ssmj_phase_e ph;
  logic [31:0] lk, lc, ld, lsk, lsc, lsd, rk, rc, rdd, rsk, rsc, rsd;
  logic [FILL_W-1:0] fill;
  logic        rse;
  ssmj_slot_t  sl [NSLOT];
  logic [1:0]  n;
  logic        rep;
  logic        we, we2;
  logic [SPOOL_AW-1:0] waddr;
  logic [SPOOL_W-1:0]  wdata, wdata2;
  logic        fire;

  logic        ram_we;
  logic [SPOOL_AW-1:0] ram_waddr;
  logic [SPOOL_W-1:0]  ram_wdata, ram_rdata;

  assign fire    = q_valid_i && (gen_q == G_IDLE);
  assign q_pop_o = fire;

  always_comb begin
    logic [31:0] t0, t1, t2, k, c, p;
    logic        e, ls_eq, rs_eq;
    ph = phase_q; lk = lk_q; lc = lc_q; ld = ld_q;
    lsk = lsk_q; lsc = lsc_q; lsd = lsd_q;
    rk = rk_q; rc = rc_q; rdd = rd_q; rsk = rsk_q; rsc = rsc_q; rsd = rsd_q;
    fill = fill_q; rse = rse_q;
    for (int i = 0; i < NSLOT; i++) begin
      sl[i] = ssmj_ctl(K_FIN);
    end
    n = 2'd0; rep = 1'b0;
    we = 1'b0; we2 = 1'b0; waddr = '0; wdata = '0; wdata2 = '0;
    k = q_data_i.key; c = q_data_i.count; p = q_data_i.payload; e = q_data_i.ended;
    t0 = '0; t1 = '0; t2 = '0; ls_eq = 1'b0; rs_eq = 1'b0;

    if (!q_data_i.req_type) begin
      lk = '0; lc = '0; ld = '0; lsk = '0; lsc = '0; lsd = '0;
      rk = '0; rc = '0; rdd = '0; rsk = '0; rsc = '0; rsd = '0;
      fill = '0; rse = 1'b0;
      sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_FIRST_L;
    end else begin
      unique case (phase_q)
        PH_FIN: ;
        PH_FIRST_L: begin
          if (e) begin
            sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
          end else begin
            lk = k; lc = c; ld = p;
            sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_FIRST_R;
          end
        end
        PH_FIRST_R, PH_SCAN_R, PH_SCAN_L: begin
          if (e) begin
            sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
          end else begin
            if (phase_q == PH_SCAN_L) begin
              lk = k; lc = c; ld = p;
            end else begin
              rk = k; rc = c; rdd = p;
            end
            if (lk < rk) begin
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_SCAN_L;
            end else if (lk > rk) begin
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SCAN_R;
            end else begin
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_MATCH_L;
            end
          end
        end
        PH_MATCH_L: begin
          if (e) begin
            sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
            sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_EMPTY_LEFT;
          end else begin
            lsk = k; lsc = c; lsd = p;
            rsk = rk; rsc = rc; rsd = rdd;
            sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_MATCH_R;
          end
        end
        PH_MATCH_R: begin
          sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
          if (e) begin
            t0 = lk; lk = lsk; lsk = t0;
            t1 = lc; lc = lsc; lsc = t1;
            t2 = ld; ld = lsd; lsd = t2;
            if (lk > rk) begin
              if (drain_q) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_DRAIN_L;
              end else begin
                sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
              end
            end else begin
              if (lk == rk) begin
                sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              end
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_EMPTY_RIGHT;
            end
          end else begin
            rsk = k; rsc = c; rsd = p;
            ls_eq = (lsk == lk);
            rs_eq = (rsk == rk);
            if (ls_eq && rs_eq) begin
              we = 1'b1; waddr = '0; wdata = {rc, rdd[PAYLOAD_WIDTH-1:0]};
              we2 = 1'b1; wdata2 = {c, p[PAYLOAD_WIDTH-1:0]};
              fill = FILL_W'(2); rse = 1'b0;
              sl[n] = ssmj_row(lk, lc, ld, c, p); n = n + 2'd1;
              rsk = rk; rsc = rc; rsd = rdd;
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SPOOL;
            end else if (ls_eq) begin
              t0 = lk; lk = lsk; lsk = t0;
              t1 = lc; lc = lsc; lsc = t1;
              t2 = ld; ld = lsd; lsd = t2;
              sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_EQ_LEFT;
            end else if (rs_eq) begin
              t0 = rk; rk = rsk; rsk = t0;
              t1 = rc; rc = rsc; rsc = t1;
              t2 = rdd; rdd = rsd; rsd = t2;
              sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_EQ_RIGHT;
            end else begin
              t0 = lk; lk = lsk; lsk = t0;
              t1 = lc; lc = lsc; lsc = t1;
              t2 = ld; ld = lsd; lsd = t2;
              t0 = rk; rk = rsk; rsk = t0;
              t1 = rc; rc = rsc; rsc = t1;
              t2 = rdd; rdd = rsd; rsd = t2;
              if (lk < rk) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_SCAN_L;
              end else if (lk > rk) begin
                sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SCAN_R;
              end else begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_MATCH_L;
              end
            end
          end
        end
        PH_EQ_LEFT: begin
          if (e) begin
            if (drain_q) begin
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_DRAIN_R;
            end else begin
              sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
            end
          end else begin
            lk = k; lc = c; ld = p;
            if (k != lsk) begin
              t0 = rk; rk = rsk; rsk = t0;
              t1 = rc; rc = rsc; rsc = t1;
              t2 = rdd; rdd = rsd; rsd = t2;
              if (lk < rk) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_SCAN_L;
              end else if (lk > rk) begin
                sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SCAN_R;
              end else begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_MATCH_L;
              end
            end else begin
              sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_EQ_LEFT;
            end
          end
        end
        PH_EQ_RIGHT: begin
          if (e) begin
            if (drain_q) begin
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_DRAIN_L;
            end else begin
              sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
            end
          end else begin
            rk = k; rc = c; rdd = p;
            if (k != rsk) begin
              t0 = lk; lk = lsk; lsk = t0;
              t1 = lc; lc = lsc; lsc = t1;
              t2 = ld; ld = lsd; lsd = t2;
              if (lk < rk) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_SCAN_L;
              end else if (lk > rk) begin
                sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SCAN_R;
              end else begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_MATCH_L;
              end
            end else begin
              sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_EQ_RIGHT;
            end
          end
        end
        PH_EMPTY_LEFT: begin
          if (e) begin
            sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
          end else begin
            rk = k; rc = c; rdd = p;
            if (lk < k) begin
              if (drain_q) begin
                sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_DRAIN_R;
              end else begin
                sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
              end
            end else begin
              if (lk == k) begin
                sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              end
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_EMPTY_LEFT;
            end
          end
        end
        PH_EMPTY_RIGHT: begin
          if (e) begin
            sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
          end else begin
            lk = k; lc = c; ld = p;
            if (lk > rk) begin
              if (drain_q) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_DRAIN_L;
              end else begin
                sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
              end
            end else begin
              if (lk == rk) begin
                sl[n] = ssmj_row(lk, lc, ld, rc, rdd); n = n + 2'd1;
              end
              sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_EMPTY_RIGHT;
            end
          end
        end
        PH_SPOOL: begin
          if (!e && (k == rsk)) begin
            if (fill >= FILL_W'(SPOOL_DEPTH)) begin
              sl[n] = ssmj_ctl(K_OVF); n = n + 2'd1; ph = PH_FIN;
            end else begin
              we = 1'b1; waddr = fill[SPOOL_AW-1:0];
              wdata = {c, p[PAYLOAD_WIDTH-1:0]};
              fill = fill + FILL_W'(1);
              rk = k; rc = c; rdd = p;
              sl[n] = ssmj_row(lk, lc, ld, c, p); n = n + 2'd1;
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SPOOL;
            end
          end else begin
            rse = e;
            if (!e) begin
              rsk = k; rsc = c; rsd = p;
            end
            t0 = lk; lk = lsk; lsk = t0;
            t1 = lc; lc = lsc; lsc = t1;
            t2 = ld; ld = lsd; lsd = t2;
            rep = 1'b1; ph = PH_SPOOL_L;
          end
        end
        PH_SPOOL_L: begin
          if (e) begin
            if (rse || !drain_q) begin
              sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
            end else begin
              sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_DRAIN_R;
            end
          end else begin
            lk = k; lc = c; ld = p;
            if (k == lsk) begin
              rep = 1'b1; ph = PH_SPOOL_L;
            end else if (rse) begin
              if (drain_q) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_DRAIN_L;
              end else begin
                sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
              end
            end else begin
              rk = rsk; rc = rsc; rdd = rsd;
              if (lk < rk) begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_SCAN_L;
              end else if (lk > rk) begin
                sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_SCAN_R;
              end else begin
                sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_MATCH_L;
              end
            end
          end
        end
        PH_DRAIN_L: begin
          if (e) begin
            sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
          end else begin
            sl[n] = ssmj_ctl(K_WANT_L); n = n + 2'd1; ph = PH_DRAIN_L;
          end
        end
        PH_DRAIN_R: begin
          if (e) begin
            sl[n] = ssmj_ctl(K_FIN); n = n + 2'd1; ph = PH_FIN;
          end else begin
            sl[n] = ssmj_ctl(K_WANT_R); n = n + 2'd1; ph = PH_DRAIN_R;
          end
        end
        default: ;
      endcase
    end
  end

  // beat sequencer: next state
  always_comb begin
    gen_d  = gen_q;
    ptr_d  = ptr_q;
    idx_d  = idx_q;
    pend_d = pend_q;
    unique case (gen_q)
      G_IDLE: begin
        if (fire) begin
          ptr_d  = 2'd0;
          idx_d  = '0;
          pend_d = 1'b0;
          if (rep) begin
            gen_d = G_REPLAY;
          end else if (n != 2'd0) begin
            gen_d = G_FIX;
          end
        end
      end
      G_FIX: begin
        if (gen_ready_i) begin
          ptr_d = ptr_q + 2'd1;
          if (ptr_q == nfix_q - 2'd1) begin
            gen_d = G_IDLE;
          end
        end
      end
      G_REPLAY: begin
        if (idx_q < fill_q) begin
          if (!pend_q) begin
            pend_d = 1'b1;
          end else if (gen_ready_i) begin
            idx_d  = idx_q + FILL_W'(1);
            pend_d = 1'b0;
          end
        end else if (gen_ready_i) begin
          gen_d = G_IDLE;
        end
      end
      default: gen_d = G_IDLE;
    endcase
  end

  // beat sequencer: outputs
  always_comb begin
    gen_valid_o = 1'b0;
    gen_data_o  = '0;
    unique case (gen_q)
      G_IDLE: ;
      G_FIX: begin
        gen_valid_o     = 1'b1;
        gen_data_o.slot = slots_q[ptr_q];
        gen_data_o.last = (ptr_q == nfix_q - 2'd1);
      end
      G_REPLAY: begin
        if (idx_q < fill_q) begin
          gen_valid_o     = pend_q;
          gen_data_o.slot = ssmj_row(lk_q, lc_q, ld_q, ram_rdata[SPOOL_W-1 -: 32],
                                     32'(ram_rdata[PAYLOAD_WIDTH-1:0]));
        end else begin
          gen_valid_o     = 1'b1;
          gen_data_o.slot = ssmj_ctl(K_WANT_L);
          gen_data_o.last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign ram_we    = (fire && we) || wr2_q;
  assign ram_waddr = wr2_q ? SPOOL_AW'(1) : waddr;
  assign ram_wdata = wr2_q ? wdata2_q : wdata;

  ssmj_ram #(
    .WIDTH (SPOOL_W),
    .DEPTH (SPOOL_DEPTH)
  ) u_spool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[SPOOL_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (fire) begin
      for (int i = 0; i < NSLOT; i++) begin
        slots_q[i] <= sl[i];
      end
      wdata2_q <= wdata2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      phase_q <= PH_FIN;
      lk_q <= '0; lc_q <= '0; ld_q <= '0; lsk_q <= '0; lsc_q <= '0; lsd_q <= '0;
      rk_q <= '0; rc_q <= '0; rd_q <= '0; rsk_q <= '0; rsc_q <= '0; rsd_q <= '0;
      fill_q <= '0;
      rse_q  <= 1'b0;
      gen_q  <= G_IDLE;
      nfix_q <= 2'd0;
      ptr_q  <= 2'd0;
      idx_q  <= '0;
      pend_q <= 1'b0;
      wr2_q  <= 1'b0;
    end else begin
      if (drain_we_i) begin
        drain_q <= drain_i;
      end
      if (fire) begin
        phase_q <= ph;
        lk_q <= lk; lc_q <= lc; ld_q <= ld; lsk_q <= lsk; lsc_q <= lsc; lsd_q <= lsd;
        rk_q <= rk; rc_q <= rc; rd_q <= rdd; rsk_q <= rsk; rsc_q <= rsc; rsd_q <= rsd;
        fill_q <= fill;
        rse_q  <= rse;
        nfix_q <= n;
      end
      wr2_q  <= fire && we2;
      gen_q  <= gen_d;
      ptr_q  <= ptr_d;
      idx_q  <= idx_d;
      pend_q <= pend_d;
    end
  end
endmodule

// File: design/ssmj_emit.sv
// ----------------------------------------------------------------------------
// ssmj_emit
// Count product stage and output register of the result channel.
// ----------------------------------------------------------------------------
module ssmj_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                gen_valid_i,
  input  ssmj_pkg::ssmj_gen_t gen_data_i,
  output logic                gen_ready_o,
  ssmj_out_if.source          out_o
);
  import ssmj_pkg::*;

  logic        a_v_q, o_v_q;
  logic [2:0]  a_kind_q, o_kind_q;
  logic [31:0] a_key_q, a_lp_q, a_rp_q, a_prod_q;
  logic [31:0] o_key_q, o_lp_q, o_rp_q, o_prod_q;
  logic        a_last_q, o_last_q;
  logic        o_free, a_move, a_load;
  logic [31:0] prod;

  assign o_free      = !o_v_q || out_o.ready;
  assign a_move      = a_v_q && o_free;
  assign gen_ready_o = !a_v_q || o_free;
  assign a_load      = gen_valid_i && gen_ready_o;
  assign prod        = gen_data_i.slot.lc * gen_data_i.slot.rc;

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_kind_q <= 3'(gen_data_i.slot.kind);
      a_key_q  <= gen_data_i.slot.key;
      a_lp_q   <= gen_data_i.slot.lp;
      a_rp_q   <= gen_data_i.slot.rp;
      a_prod_q <= prod;
      a_last_q <= gen_data_i.last;
    end
    if (a_move) begin
      o_kind_q <= a_kind_q;
      o_key_q  <= a_key_q;
      o_lp_q   <= a_lp_q;
      o_rp_q   <= a_rp_q;
      o_prod_q <= a_prod_q;
      o_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (gen_ready_o) begin
        a_v_q <= gen_valid_i;
      end
      if (o_free) begin
        o_v_q <= a_v_q;
      end
    end
  end

  assign out_o.valid         = o_v_q;
  assign out_o.kind          = o_kind_q;
  assign out_o.match_key     = o_key_q;
  assign out_o.left_payload  = o_lp_q;
  assign out_o.right_payload = o_rp_q;
  assign out_o.multiplicity  = o_prod_q;
  assign out_o.last          = o_last_q;
endmodule

// File: design/sorted_stream_merge_join.sv
// ----------------------------------------------------------------------------
// sorted_stream_merge_join
// Sort-merge equi-join of two ascending tuple streams with spooled n:m runs.
// Order: a request beat passes the front queue, then the engine's slot
// registers, then the emit and output registers before its first result
// beat is valid; a spool replay also waits on the registered spool read.
// The next request waits until all beats of the previous one have left
// the sequencer.
// Reset: asynchronous, clears tuple state and the mode register; no sweep.
// ----------------------------------------------------------------------------
module sorted_stream_merge_join (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        drain_on_finish_we_i,
  input  logic        drain_on_finish_i,
  ssmj_in_if.sink     in_i,
  ssmj_out_if.source  out_o
);
  import ssmj_pkg::*;

  logic       q_valid, q_pop, gen_valid, gen_ready;
  ssmj_beat_t q_data;
  ssmj_gen_t  gen_data;

  ssmj_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_data_o  (q_data),
    .q_pop_i   (q_pop)
  );

  ssmj_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .drain_we_i  (drain_on_finish_we_i),
    .drain_i     (drain_on_finish_i),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .gen_valid_o (gen_valid),
    .gen_data_o  (gen_data),
    .gen_ready_i (gen_ready)
  );

  ssmj_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gen_valid_i (gen_valid),
    .gen_data_i  (gen_data),
    .gen_ready_o (gen_ready),
    .out_o       (out_o)
  );
endmodule
